// ----- rtl/core/dltq_pkg.sv -----
package dltq_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int DELAY_BITS  = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // request and result codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_TICK   = 1'b1;
    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_FIRE  = 1'b1;
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_FULL    = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [15:0] delay;
        logic [15:0] handle;
        logic        action;
    } req_t;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] fired_handle;
        logic        fired_action;
        logic        status;
        logic        last;
    } res_t;

    // one callout table entry
    typedef struct packed {
        logic [DELAY_BITS-1:0] delta;
        logic [15:0]           handle;
        logic                  action;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // microprogram addresses
    typedef enum logic [3:0] {
        UC_INS_CHECK  = 4'd0,
        UC_WALK_READ  = 4'd1,
        UC_WALK_TEST  = 4'd2,
        UC_SHIFT_READ = 4'd3,
        UC_SHIFT_MOVE = 4'd4,
        UC_INS_WRITE  = 4'd5,
        UC_TICK_READ  = 4'd6,
        UC_TICK_TEST  = 4'd7,
        UC_FIRE_READ  = 4'd8,
        UC_FIRE_TEST  = 4'd9,
        UC_PACK_READ  = 4'd10,
        UC_PACK_MOVE  = 4'd11,
        UC_DONE       = 4'd12
    } uc_pc_t;

    // read port source
    typedef enum logic [1:0] {
        RD_NONE,
        RD_IDX,
        RD_IDX_M1,
        RD_ZERO
    } uc_rd_t;

    // branch condition
    typedef enum logic [3:0] {
        CND_ALWAYS,
        CND_NEVER,
        CND_FULL,
        CND_EMPTY,
        CND_WALK,
        CND_AT_POS,
        CND_HEAD_LIVE,
        CND_NEXT_ZERO,
        CND_SRC_DONE
    } uc_cond_t;

    // datapath operation
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACK_FULL,
        OP_WALK_INIT,
        OP_WALK_STEP,
        OP_WALK_END,
        OP_SHIFT,
        OP_ACK_NEW,
        OP_HEAD_WR,
        OP_FIRE_INIT,
        OP_FIRE_MORE,
        OP_FIRE_END,
        OP_MOVE,
        OP_DROP
    } uc_op_t;

    // control word: branch to target with op_t when cond holds, else fall through with op_f
    typedef struct packed {
        uc_rd_t   rd;
        uc_cond_t cond;
        uc_pc_t   target;
        uc_op_t   op_t;
        uc_op_t   op_f;
    } ctl_word_t;

    function automatic ctl_word_t uc_rom(input uc_pc_t pc);
        ctl_word_t w;
        unique case (pc)
            UC_INS_CHECK:  w = '{RD_NONE,   CND_FULL,      UC_DONE,       OP_ACK_FULL,  OP_WALK_INIT};
            UC_WALK_READ:  w = '{RD_IDX,    CND_NEVER,     UC_DONE,       OP_NOP,       OP_NOP};
            UC_WALK_TEST:  w = '{RD_NONE,   CND_WALK,      UC_WALK_READ,  OP_WALK_STEP, OP_WALK_END};
            UC_SHIFT_READ: w = '{RD_IDX_M1, CND_AT_POS,    UC_INS_WRITE,  OP_NOP,       OP_NOP};
            UC_SHIFT_MOVE: w = '{RD_NONE,   CND_ALWAYS,    UC_SHIFT_READ, OP_SHIFT,     OP_NOP};
            UC_INS_WRITE:  w = '{RD_NONE,   CND_ALWAYS,    UC_DONE,       OP_ACK_NEW,   OP_NOP};
            UC_TICK_READ:  w = '{RD_ZERO,   CND_EMPTY,     UC_DONE,       OP_NOP,       OP_NOP};
            UC_TICK_TEST:  w = '{RD_NONE,   CND_HEAD_LIVE, UC_DONE,       OP_HEAD_WR,   OP_FIRE_INIT};
            UC_FIRE_READ:  w = '{RD_IDX,    CND_NEVER,     UC_DONE,       OP_NOP,       OP_NOP};
            UC_FIRE_TEST:  w = '{RD_NONE,   CND_NEXT_ZERO, UC_FIRE_READ,  OP_FIRE_MORE, OP_FIRE_END};
            UC_PACK_READ:  w = '{RD_IDX,    CND_SRC_DONE,  UC_DONE,       OP_DROP,      OP_NOP};
            UC_PACK_MOVE:  w = '{RD_NONE,   CND_ALWAYS,    UC_PACK_READ,  OP_MOVE,      OP_NOP};
            default:       w = '{RD_NONE,   CND_ALWAYS,    UC_DONE,       OP_NOP,       OP_NOP};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/dltq_ram.sv -----
module dltq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/delta_list_timer_queue_core.sv -----
// an insert walks past the entries it follows, then shifts the later entries down to make room
// a full-table insert and a tick on an empty table end after their first check; a silent tick writes the head back
// a firing tick reports each fired entry, then packs the remaining ones; a ram read step before each entry use
// throughput: one request at a time, start is taken only while busy is low
// results are registered and appear in the cycle after the step that makes them; they are never stalled
// reset clears the sequencer, the strobe and the entry count; the entry ram is not cleared
module delta_list_timer_queue_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  dltq_pkg::req_t  req,
    output logic            result_valid,
    output dltq_pkg::res_t  result
);

    import dltq_pkg::*;

    // sequencer state
    uc_pc_t    pc_reg, pc_next;
    logic      run_reg, run_next;
    ctl_word_t ctl;
    logic      cond_hit;
    uc_op_t    op;

    // datapath registers
    req_t                  req_reg, req_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic [DELAY_BITS-1:0] t_reg, t_next;
    entry_t                ent_reg, ent_next;
    res_t                  result_reg, result_next;
    logic                  result_valid_reg, result_valid_next;

    // entry ram ports
    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    entry_t             ram_wdata, rd_ent;
    logic [ENTRY_W-1:0] ram_rdata;

    // scratch values
    logic [CNT_W-1:0] idx_m1, idx_p1, pos_p1, dst_idx;

    assign ctl     = uc_rom(pc_reg);
    assign rd_ent  = entry_t'(ram_rdata);
    assign idx_m1  = CNT_W'(idx_reg - 1'b1);
    assign idx_p1  = CNT_W'(idx_reg + 1'b1);
    assign pos_p1  = CNT_W'(pos_reg + 1'b1);
    assign dst_idx = CNT_W'(idx_reg - pos_reg);

    dltq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // branch condition for the current control word
    always_comb
    begin
        unique case (ctl.cond)
            CND_ALWAYS:    cond_hit = 1'b1;
            CND_NEVER:     cond_hit = 1'b0;
            CND_FULL:      cond_hit = (count_reg == CNT_W'(TABLE_DEPTH));
            CND_EMPTY:     cond_hit = (count_reg == '0);
            // keep walking while the passed delta fits in the remaining delay
            CND_WALK:      cond_hit = (idx_reg < count_reg) && (rd_ent.delta <= t_reg);
            CND_AT_POS:    cond_hit = (idx_reg == pos_reg);
            // head still waiting after the decrement
            CND_HEAD_LIVE: cond_hit = (rd_ent.delta > DELAY_BITS'(1));
            // next entry fires together with the current one
            CND_NEXT_ZERO: cond_hit = (idx_reg < count_reg) && (rd_ent.delta == '0);
            CND_SRC_DONE:  cond_hit = (idx_reg >= count_reg);
            default:       cond_hit = 1'b0;
        endcase
    end

    assign op = cond_hit ? ctl.op_t : ctl.op_f;

    // sequencer and datapath control
    always_comb
    begin
        pc_next           = pc_reg;
        run_next          = run_reg;
        req_next          = req_reg;
        count_next        = count_reg;
        idx_next          = idx_reg;
        pos_next          = pos_reg;
        t_next            = t_reg;
        ent_next          = ent_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = idx_reg[ADDR_W-1:0];
        ram_wdata         = rd_ent;
        ram_re            = 1'b0;
        ram_raddr         = idx_reg[ADDR_W-1:0];

        if (!run_reg)
        begin
            // idle: take a new request word
            if (start)
            begin
                req_next = req;
                run_next = 1'b1;
                pc_next  = (req.req_type == REQ_TICK) ? UC_TICK_READ : UC_INS_CHECK;
            end
        end
        else
        begin
            pc_next = cond_hit ? ctl.target : uc_pc_t'(pc_reg + 1'b1);
            if (pc_next == UC_DONE)
            begin
                run_next = 1'b0;
            end

            // read port
            unique case (ctl.rd)
                RD_NONE:
                begin
                    ram_re = 1'b0;
                end
                RD_IDX:
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg[ADDR_W-1:0];
                end
                RD_IDX_M1:
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_m1[ADDR_W-1:0];
                end
                RD_ZERO:
                begin
                    ram_re    = 1'b1;
                    ram_raddr = '0;
                end
                default:
                begin
                    ram_re = 1'b0;
                end
            endcase

            // datapath operation
            unique case (op)
                OP_NOP:
                begin
                    idx_next = idx_reg;
                end
                OP_ACK_FULL:
                begin
                    result_valid_next = 1'b1;
                    result_next       = '{KIND_ACK, req_reg.handle, req_reg.action,
                                          ST_FULL, 1'b1};
                end
                OP_WALK_INIT:
                begin
                    idx_next = '0;
                    t_next   = DELAY_BITS'(req_reg.delay);
                end
                OP_WALK_STEP:
                begin
                    t_next   = t_reg - rd_ent.delta;
                    idx_next = idx_p1;
                end
                OP_WALK_END:
                begin
                    // slot found, shift from the tail down to it
                    pos_next = idx_reg;
                    idx_next = count_reg;
                end
                OP_SHIFT:
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg[ADDR_W-1:0];
                    ram_wdata = rd_ent;
                    // the entry displaced from the slot loses the new entry's delta
                    if (idx_reg == pos_p1)
                    begin
                        ram_wdata.delta = rd_ent.delta - t_reg;
                    end
                    idx_next = idx_m1;
                end
                OP_ACK_NEW:
                begin
                    ram_we            = 1'b1;
                    ram_waddr         = pos_reg[ADDR_W-1:0];
                    ram_wdata         = '{t_reg, req_reg.handle, req_reg.action};
                    count_next        = CNT_W'(count_reg + 1'b1);
                    result_valid_next = 1'b1;
                    result_next       = '{KIND_ACK, req_reg.handle, req_reg.action,
                                          ST_OK, 1'b1};
                end
                OP_HEAD_WR:
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = '0;
                    ram_wdata       = rd_ent;
                    ram_wdata.delta = rd_ent.delta - 1'b1;
                end
                OP_FIRE_INIT:
                begin
                    // head fires; it is dropped by the compaction, so no write back
                    ent_next = rd_ent;
                    idx_next = CNT_W'(1);
                end
                OP_FIRE_MORE:
                begin
                    result_valid_next = 1'b1;
                    result_next       = '{KIND_FIRE, ent_reg.handle, ent_reg.action,
                                          ST_OK, 1'b0};
                    ent_next          = rd_ent;
                    idx_next          = idx_p1;
                end
                OP_FIRE_END:
                begin
                    result_valid_next = 1'b1;
                    result_next       = '{KIND_FIRE, ent_reg.handle, ent_reg.action,
                                          ST_OK, 1'b1};
                    // fired count, also the move distance
                    pos_next          = idx_reg;
                end
                OP_MOVE:
                begin
                    ram_we    = 1'b1;
                    ram_waddr = dst_idx[ADDR_W-1:0];
                    ram_wdata = rd_ent;
                    idx_next  = idx_p1;
                end
                OP_DROP:
                begin
                    count_next = CNT_W'(count_reg - pos_reg);
                end
                default:
                begin
                    idx_next = idx_reg;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg           <= UC_DONE;
            run_reg          <= 1'b0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg           <= pc_next;
            run_reg          <= run_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        t_reg      <= t_next;
        ent_reg    <= ent_next;
        result_reg <= result_next;
    end

    assign busy         = run_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- rtl/core/dltq_chk.sv -----
module dltq_chk (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input dltq_pkg::req_t req,
    input logic           result_valid,
    input dltq_pkg::res_t result
);

    import dltq_pkg::*;

    // a result word only follows a busy cycle
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result word without preceding busy cycle");

    // an accepted request word makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // an acknowledgement is always the only result of its request
    a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.result_kind == KIND_ACK) |-> result.last)
        else $error("acknowledgement without last");

    // fired reports never carry the full status
    a_fire_status: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.result_kind == KIND_FIRE) |-> (result.status == ST_OK))
        else $error("fired report with full status");

    // nothing follows directly after the last word of a request
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |=> !result_valid)
        else $error("result word right after last");

endmodule

bind delta_list_timer_queue_core dltq_chk u_dltq_chk (.*);

// ----- tb/sv/delta_list_timer_queue_core_tb.sv -----
module delta_list_timer_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dltq_pkg::*;

    // run bounds: loose limits for the watchdog and the final drain
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 150;
    localparam int RANDOM_WORDS = 196;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req = '0;
    logic busy;
    logic result_valid;
    res_t result;

    delta_list_timer_queue_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .result_valid (result_valid),
        .result       (result)
    );

    // request words waiting to be sent, filled once by the stimulus block
    req_t req_backlog[$];
    // result words the block still owes, oldest first
    res_t due_results[$];

    // shadow copy of the callout table
    logic [DELAY_BITS-1:0] shadow_delta[TABLE_DEPTH];
    logic [15:0]           shadow_handle[TABLE_DEPTH];
    logic                  shadow_action[TABLE_DEPTH];
    int                    shadow_count = 0;

    int words_total = 0;
    int words_taken = 0;
    int inserts_taken = 0;
    int ticks_taken = 0;
    int mismatch_count = 0;
    int results_seen = 0;
    int acks_seen = 0;
    int full_seen = 0;
    int fires_seen = 0;
    int cycle_count = 0;

    // clock, 2 ns period
    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // table shadow: insert walks the delta list and splices the new entry
    // ------------------------------------------------------------------
    function automatic void shadow_insert(input req_t r);
        logic [DELAY_BITS-1:0] left;
        int pos;
        int j;
        res_t ack;
        left = r.delay[DELAY_BITS-1:0];
        pos = 0;
        ack = '{KIND_ACK, r.handle, r.action, ST_OK, 1'b1};
        // full table: nothing moves, the ack carries the full status
        if (shadow_count >= TABLE_DEPTH)
        begin
            ack.status = ST_FULL;
            due_results.push_back(ack);
            return;
        end
        // pass every entry whose delta fits in what is left, so equal
        // deadlines land behind the ones already queued
        while (pos < shadow_count && shadow_delta[pos] <= left)
        begin
            left -= shadow_delta[pos];
            pos++;
        end
        // the follower now counts from the new entry
        if (pos < shadow_count)
            shadow_delta[pos] -= left;
        for (j = shadow_count; j > pos; j--)
        begin
            shadow_delta[j]  = shadow_delta[j-1];
            shadow_handle[j] = shadow_handle[j-1];
            shadow_action[j] = shadow_action[j-1];
        end
        shadow_delta[pos]  = left;
        shadow_handle[pos] = r.handle;
        shadow_action[pos] = r.action;
        shadow_count++;
        due_results.push_back(ack);
    endfunction

    // tick: head counts down to zero, then the zero-delta run fires and is removed
    function automatic void shadow_tick();
        int n;
        int i;
        res_t fire;
        // empty table ignores the tick
        if (shadow_count == 0)
            return;
        if (shadow_delta[0] != '0)
            shadow_delta[0]--;
        // head still live: silent tick
        if (shadow_delta[0] != '0)
            return;
        n = 0;
        while (n < shadow_count && shadow_delta[n] == '0)
            n++;
        for (i = 0; i < n; i++)
        begin
            fire = '{KIND_FIRE, shadow_handle[i], shadow_action[i], ST_OK,
                     logic'(i + 1 == n)};
            due_results.push_back(fire);
        end
        for (i = n; i < shadow_count; i++)
        begin
            shadow_delta[i-n]  = shadow_delta[i];
            shadow_handle[i-n] = shadow_handle[i];
            shadow_action[i-n] = shadow_action[i];
        end
        shadow_count -= n;
    endfunction

    function automatic void apply_request(input req_t r);
        if (r.req_type == REQ_INSERT)
        begin
            inserts_taken++;
            shadow_insert(r);
        end
        else
        begin
            ticks_taken++;
            shadow_tick();
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic req_t insert_word(input logic [15:0] d, input logic [15:0] h,
                                         input logic a);
        req_t r;
        r.req_type = REQ_INSERT;
        r.delay    = d;
        r.handle   = h;
        r.action   = a;
        return r;
    endfunction

    // the tick ignores the other fields, so they carry noise
    function automatic req_t tick_word();
        req_t r;
        r.req_type = REQ_TICK;
        r.delay    = 16'($urandom);
        r.handle   = 16'($urandom);
        r.action   = 1'($urandom);
        return r;
    endfunction

    // mostly short timeouts so entries keep draining; a few medium ones walk
    // deeper, and rare long ones stay parked at the tail
    function automatic logic [15:0] pick_delay();
        int p;
        p = $urandom_range(0, 99);
        if (p < 2)
            return 16'($urandom);
        else if (p < 12)
            return 16'($urandom_range(0, 40));
        return 16'($urandom_range(0, 6));
    endfunction

    function automatic req_t random_insert();
        return insert_word(pick_delay(), 16'($urandom), 1'($urandom));
    endfunction

    // sender gaps by phase: none, 68 of 100, none (receiver phase: it cannot
    // hold words off), 36 of 100, then none again
    function automatic int sender_idle_pct(input int n);
        if (n < 50)
            return 0;
        if (n < 110)
            return 68;
        if (n < 150)
            return 0;
        if (n < 200)
            return 36;
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // request driver: hold start until the word is taken, then present the
    // next one or idle; at most one nonblocking write per signal per edge
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req   <= '0;
        end
        else
        begin
            // word taken at this edge
            if (start && !busy)
            begin
                apply_request(req);
                words_taken++;
            end
            // a pending word stays put while busy holds it off
            if (!start || !busy)
            begin
                if (req_backlog.size() != 0
                    && $urandom_range(0, 99) >= sender_idle_pct(words_taken))
                begin
                    start <= 1'b1;
                    req   <= req_backlog.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                    req   <= req_t'($bits(req_t)'({$urandom, $urandom}));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: every strobed word is matched against the oldest one owed
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] result %0d: %s got %0h, want %0h", $realtime, results_seen, what,
                 got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && result_valid)
        begin
            if (result.result_kind == KIND_FIRE)
                fires_seen++;
            else if (result.status == ST_FULL)
                full_seen++;
            else
                acks_seen++;
            if (due_results.size() == 0)
                report_mismatch("unexpected word, handle", result.fired_handle, '0);
            else
            begin
                want = due_results.pop_front();
                if (result.result_kind !== want.result_kind)
                    report_mismatch("result_kind", 16'(result.result_kind),
                                    16'(want.result_kind));
                if (result.fired_handle !== want.fired_handle)
                    report_mismatch("fired_handle", result.fired_handle, want.fired_handle);
                if (result.fired_action !== want.fired_action)
                    report_mismatch("fired_action", 16'(result.fired_action),
                                    16'(want.fired_action));
                if (result.status !== want.status)
                    report_mismatch("status", 16'(result.status), 16'(want.status));
                if (result.last !== want.last)
                    report_mismatch("last", 16'(result.last), 16'(want.last));
            end
            results_seen++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d of %0d words taken, %0d results owed",
                     cycle_count, words_taken, words_total, due_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        logic [15:0] dir_delay[14];
        int kind;
        int k;
        int m;
        int i;
        int rand_words;

        dir_delay = '{0, 3, 3, 1, 5, 2, 3, 0, 5, 1, 2, 6, 6, 6};

        // directed: tick on an empty table
        req_backlog.push_back(tick_word());
        // delay and handle extremes; the longest timeout parks at the tail for good
        req_backlog.push_back(insert_word(16'h0000, 16'h0000, 1'b0));
        req_backlog.push_back(insert_word(16'hFFFF, 16'hFFFF, 1'b1));
        // fill the table with repeated deadlines and zero delays, no deadline at 4
        for (i = 0; i < 14; i++)
            req_backlog.push_back(insert_word(dir_delay[i], 16'h1000 + 16'(i), 1'(i)));
        // one more insert into a full table
        req_backlog.push_back(insert_word(16'h0002, 16'hA5A5, 1'b1));
        // six ticks: multi-entry fires, a silent tick at 4, compaction after each fire
        for (i = 0; i < 6; i++)
            req_backlog.push_back(tick_word());

        // random part: mostly insert runs followed by tick runs, some fill
        // bursts that push into a full table, and some mixed noise
        rand_words = 0;
        while (rand_words < RANDOM_WORDS)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                k = $urandom_range(1, 6);
                m = $urandom_range(1, 8);
            end
            else if (kind <= 7)
            begin
                k = $urandom_range(12, 18);
                m = $urandom_range(4, 8);
            end
            else
            begin
                k = 0;
                m = $urandom_range(4, 10);
            end
            for (i = 0; i < k; i++)
                req_backlog.push_back(random_insert());
            for (i = 0; i < m; i++)
            begin
                // noise words pick their type at random
                if (kind > 7 && $urandom_range(0, 1) == 0)
                    req_backlog.push_back(random_insert());
                else
                    req_backlog.push_back(tick_word());
            end
            rand_words += k + m;
        end
        words_total = req_backlog.size();

        // reset held low at the start, released on a rising edge
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // sample on the falling edge so the driver and monitor have settled
        do
            @(negedge clk);
        while (words_taken != words_total || due_results.size() != 0);
        // a tick that fires nothing still keeps the block busy for a while
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (due_results.size() != 0)
            report_mismatch("words never returned, count", 16'(due_results.size()), '0);

        $display("sent %0d words (%0d inserts, %0d ticks) through varied sender gaps",
                 words_taken, inserts_taken, ticks_taken);
        $display("checked %0d results: %0d acks, %0d full-table drops, %0d fired entries",
                 results_seen, acks_seen, full_seen, fires_seen);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
